// ===== hdl/bdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bdsa_pkg
// Types, register codes and reset values shared by the debounce and
// setpoint adjust unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bdsa_pkg;

    // register map, one 32-bit slot per register at byte address 4*index
    typedef enum logic [2:0] {
        REG_DEBOUNCE_POLLS = 3'd0,
        REG_REST_LEVELS    = 3'd1,
        REG_ALT_STEP       = 3'd2,
        REG_ALT_MIN        = 3'd3,
        REG_ALT_MAX        = 3'd4,
        REG_YAW_STEP       = 3'd5,
        REG_YAW_MIN        = 3'd6,
        REG_FULL_CIRCLE    = 3'd7
    } reg_index_t;

    localparam logic [7:0]         RST_DEBOUNCE_POLLS = 8'd3;
    localparam logic [3:0]         RST_REST_LEVELS    = 4'd12;
    localparam logic [9:0]         RST_ALT_STEP       = 10'd10;
    localparam logic signed [15:0] RST_ALT_MIN        = 16'sd0;
    localparam logic signed [15:0] RST_ALT_MAX        = 16'sd100;
    localparam logic [8:0]         RST_YAW_STEP       = 9'd15;
    localparam logic signed [9:0]  RST_YAW_MIN        = -10'sd180;
    localparam logic [9:0]         RST_FULL_CIRCLE    = 10'd360;

    // event bit positions
    localparam int BTN_UP    = 0;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_LEFT  = 2;
    localparam int BTN_RIGHT = 3;
    localparam int EVT_BITS  = 4;

    typedef struct packed {
        logic [7:0]         debounce_polls;
        logic [3:0]         rest_levels;
        logic [9:0]         alt_step;
        logic signed [15:0] alt_min;
        logic signed [15:0] alt_max;
        logic [8:0]         yaw_step;
        logic signed [9:0]  yaw_min;
        logic [9:0]         full_circle;
    } cfg_t;

    typedef struct packed {
        logic pushed;
        logic released;
    } lane_evt_t;

    typedef struct packed {
        logic [3:0]         pushed_events;
        logic [3:0]         released_events;
        logic signed [15:0] altitude_setpoint;
        logic signed [9:0]  yaw_setpoint;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/bdsa_lane.sv =====
// ----------------------------------------------------------------------------
// bdsa_lane
// Counter-based debouncer for one button; reports push and release flips.
// ----------------------------------------------------------------------------
`default_nettype none

module bdsa_lane
    import bdsa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic       level,
    input  wire logic       rest_level,
    input  wire logic       reset_level,
    input  wire logic [7:0] debounce_polls,
    output lane_evt_t       evt
);

    logic       debounced_reg, debounced_next;
    logic [7:0] count_reg, count_next;
    logic [8:0] count_inc;
    logic       disagree;
    logic       flip;

    assign disagree  = (level != debounced_reg);
    assign count_inc = {1'b0, count_reg} + 9'd1;
    // a setting of zero behaves like one
    assign flip      = disagree && (count_inc >= {1'b0, debounce_polls});

    always_comb begin
        debounced_next = debounced_reg;
        count_next     = 8'd0;
        if (flip) begin
            debounced_next = level;
        end else if (disagree) begin
            count_next = count_inc[7:0];
        end
    end

    assign evt.pushed   = flip && (level != rest_level);
    assign evt.released = flip && (level == rest_level);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounced_reg <= reset_level;
            count_reg     <= 8'd0;
        end else if (advance) begin
            debounced_reg <= debounced_next;
            count_reg     <= count_next;
        end
    end

`ifndef SYNTH
    a_flip_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && flip) |=> (count_reg == 8'd0))
        else $error("debounce count not cleared after flip");
    a_count_below_polls: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && disagree && !flip) |=> (count_reg != 8'd0))
        else $error("disagreeing poll did not advance count");
`endif

endmodule

`default_nettype wire

// ===== hdl/bdsa_setpoint.sv =====
// ----------------------------------------------------------------------------
// bdsa_setpoint
// Merge stage: applies this beat's pushes to the altitude (clamped) and yaw
// (wrapped) setpoints in the order up, down, left, right.
// ----------------------------------------------------------------------------
`default_nettype none

module bdsa_setpoint
    import bdsa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire logic [3:0]         pushed,
    input  wire cfg_t               cfg,
    output logic signed [15:0]      alt_next,
    output logic signed [9:0]       yaw_next
);

    logic signed [15:0] alt_reg;
    logic signed [9:0]  yaw_reg;

    // altitude chain
    logic signed [17:0] alt0, alt_up_sum, alt1, alt_dn_sum, alt_max_x, alt_min_x;
    logic signed [17:0] alt_step_x;

    assign alt0       = {{2{alt_reg[15]}}, alt_reg};
    assign alt_step_x = {8'd0, cfg.alt_step};
    assign alt_max_x  = {{2{cfg.alt_max[15]}}, cfg.alt_max};
    assign alt_min_x  = {{2{cfg.alt_min[15]}}, cfg.alt_min};
    assign alt_up_sum = alt0 + alt_step_x;

    always_comb begin
        alt1 = alt0;
        if (pushed[BTN_UP]) begin
            alt1 = (alt_up_sum > alt_max_x) ? alt_max_x : alt_up_sum;
        end
    end

    assign alt_dn_sum = alt1 - alt_step_x;

    always_comb begin
        alt_next = alt1[15:0];
        if (pushed[BTN_DOWN]) begin
            alt_next = (alt_dn_sum < alt_min_x) ? alt_min_x[15:0] : alt_dn_sum[15:0];
        end
    end

    // yaw chain, 13-bit signed holds every intermediate
    logic signed [12:0] yaw0, yaw1, yaw2, st_x, fc_x, ymin_x, yaw_top;
    logic signed [12:0] left_lim;

    assign yaw0     = {{3{yaw_reg[9]}}, yaw_reg};
    assign st_x     = {4'd0, cfg.yaw_step};
    assign fc_x     = {3'd0, cfg.full_circle};
    assign ymin_x   = {{3{cfg.yaw_min[9]}}, cfg.yaw_min};
    assign left_lim = ymin_x + st_x;
    assign yaw_top  = ymin_x + fc_x - 13'sd1 - st_x;

    always_comb begin
        yaw1 = yaw0;
        if (pushed[BTN_LEFT]) begin
            yaw1 = (yaw0 >= left_lim) ? (yaw0 - st_x) : (yaw0 + fc_x - st_x);
        end
    end

    logic signed [12:0] yaw1_w;
    // wrap result is truncated to 10 bits before the next push sees it
    assign yaw1_w = {{3{yaw1[9]}}, yaw1[9:0]};

    always_comb begin
        yaw2 = yaw1_w;
        if (pushed[BTN_RIGHT]) begin
            yaw2 = (yaw1_w <= yaw_top) ? (yaw1_w + st_x) : (yaw1_w - fc_x + st_x);
        end
    end

    assign yaw_next = yaw2[9:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_reg <= 16'sd0;
            yaw_reg <= 10'sd0;
        end else if (advance) begin
            alt_reg <= alt_next;
            yaw_reg <= yaw_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bdsa_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bdsa_out_fifo
// Two-entry result buffer; decouples the result channel from the input so a
// stalled consumer does not stop the next poll beat at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bdsa_out_fifo
    import bdsa_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         not_full,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t    mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign not_full  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("result buffer written while full");
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("result buffer pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ===== hdl/button_debounce_setpoint_adjust_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_setpoint_adjust_unit
// Per-button debounce lanes feeding a setpoint merge stage, with an APB
// register bank and a two-entry result buffer.
// ----------------------------------------------------------------------------
// Throughput: one poll beat per cycle while the result buffer is not
//   full; debounce lanes and the setpoint chain update their state on
//   the edge that accepts the beat, and its result enters the buffer.
// Reset: synchronous, active low; registers return to defaults, debounced
//   levels to the default rest levels, counters and setpoints to zero,
//   result buffer empty. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_setpoint_adjust_unit
    import bdsa_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // poll beats
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_button_levels,
    // results
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_pushed_events,
    output logic [3:0]              m_released_events,
    output logic signed [15:0]      m_altitude_setpoint,
    output logic signed [9:0]       m_yaw_setpoint,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    reg_index_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_polls <= RST_DEBOUNCE_POLLS;
            cfg_reg.rest_levels    <= RST_REST_LEVELS;
            cfg_reg.alt_step       <= RST_ALT_STEP;
            cfg_reg.alt_min        <= RST_ALT_MIN;
            cfg_reg.alt_max        <= RST_ALT_MAX;
            cfg_reg.yaw_step       <= RST_YAW_STEP;
            cfg_reg.yaw_min        <= RST_YAW_MIN;
            cfg_reg.full_circle    <= RST_FULL_CIRCLE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DEBOUNCE_POLLS: cfg_reg.debounce_polls <= pwdata[7:0];
                REG_REST_LEVELS:    cfg_reg.rest_levels    <= pwdata[3:0];
                REG_ALT_STEP:       cfg_reg.alt_step       <= pwdata[9:0];
                REG_ALT_MIN:        cfg_reg.alt_min        <= pwdata[15:0];
                REG_ALT_MAX:        cfg_reg.alt_max        <= pwdata[15:0];
                REG_YAW_STEP:       cfg_reg.yaw_step       <= pwdata[8:0];
                REG_YAW_MIN:        cfg_reg.yaw_min        <= pwdata[9:0];
                REG_FULL_CIRCLE:    cfg_reg.full_circle    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DEBOUNCE_POLLS: prdata = {24'd0, cfg_reg.debounce_polls};
            REG_REST_LEVELS:    prdata = {28'd0, cfg_reg.rest_levels};
            REG_ALT_STEP:       prdata = {22'd0, cfg_reg.alt_step};
            REG_ALT_MIN:        prdata = {16'd0, cfg_reg.alt_min};
            REG_ALT_MAX:        prdata = {16'd0, cfg_reg.alt_max};
            REG_YAW_STEP:       prdata = {23'd0, cfg_reg.yaw_step};
            REG_YAW_MIN:        prdata = {22'd0, cfg_reg.yaw_min};
            REG_FULL_CIRCLE:    prdata = {22'd0, cfg_reg.full_circle};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- debounce lanes ----------------
    logic      advance;
    logic      buf_not_full;
    lane_evt_t lane_evt [NUM_BUTTONS];

    assign s_ready = buf_not_full;
    assign advance = s_valid && s_ready;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        logic lvl, rest, rst_lvl;
        if (i < EVT_BITS) begin : g_real
            assign lvl     = s_button_levels[i];
            assign rest    = cfg_reg.rest_levels[i];
            assign rst_lvl = RST_REST_LEVELS[i];
        end else begin : g_extra
            // extra buttons sit at level zero with rest level zero
            assign lvl     = 1'b0;
            assign rest    = 1'b0;
            assign rst_lvl = 1'b0;
        end

        bdsa_lane u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .advance        (advance),
            .level          (lvl),
            .rest_level     (rest),
            .reset_level    (rst_lvl),
            .debounce_polls (cfg_reg.debounce_polls),
            .evt            (lane_evt[i])
        );
    end

    logic [3:0] pushed4, released4;

    for (genvar j = 0; j < EVT_BITS; j++) begin : g_evt
        if (j < NUM_BUTTONS) begin : g_on
            assign pushed4[j]   = lane_evt[j].pushed;
            assign released4[j] = lane_evt[j].released;
        end else begin : g_off
            assign pushed4[j]   = 1'b0;
            assign released4[j] = 1'b0;
        end
    end

    // ---------------- merge stage ----------------
    logic signed [15:0] alt_next;
    logic signed [9:0]  yaw_next;

    bdsa_setpoint u_setpoint (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .pushed   (pushed4),
        .cfg      (cfg_reg),
        .alt_next (alt_next),
        .yaw_next (yaw_next)
    );

    // ---------------- result buffer ----------------
    result_t res_in, res_out;

    assign res_in.pushed_events     = pushed4;
    assign res_in.released_events   = released4;
    assign res_in.altitude_setpoint = alt_next;
    assign res_in.yaw_setpoint      = yaw_next;

    bdsa_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance),
        .push_data (res_in),
        .not_full  (buf_not_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign m_pushed_events     = res_out.pushed_events;
    assign m_released_events   = res_out.released_events;
    assign m_altitude_setpoint = res_out.altitude_setpoint;
    assign m_yaw_setpoint      = res_out.yaw_setpoint;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button debounce and setpoint adjust unit.
// A directed table covers reset behavior, bounce rejection, simultaneous
// pushes, clamp and wrap corners and rest-level rewrites. Random phases then
// run under several register settings and handshake patterns. Every result
// beat is checked against an in-bench model of the debounce lanes and the
// setpoint chain, or against the table's result where a row gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import bdsa_pkg::*;

    localparam int  ITEMS_PER_PHASE = 175;
    localparam int  PHASES          = 8;
    localparam int  HOLD_CYCLES     = 60;
    localparam int  MAX_REPORTS     = 10;
    localparam real RUN_LIMIT_NS    = 2_000_000.0;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum logic {
        ROW_POLL,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        reg_index_t reg_sel;
        logic [31:0] wdata;
        logic [3:0] levels;
        logic       typed;
        result_t    want;
    } plan_row_t;

    localparam result_t QUIET    = '0;
    localparam result_t FIRST_UP = '{4'b0001, 4'b0000, 16'sd10, 10'sd0};

    localparam int PLAN_ROWS = 37;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // reset settings: up and down rest low, left and right rest high
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b1, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1101, 1'b1, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1101, 1'b1, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1101, 1'b1, FIRST_UP},
        // bounce, then an agreeing poll clears the count
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1101, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        // zero debounce behaves like one; all four pushed in one poll
        '{ROW_WRITE, REG_DEBOUNCE_POLLS, 32'd0,         4'b0000, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b0011, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        // clamp limits crossed: up then down, the later push wins
        '{ROW_WRITE, REG_ALT_MIN,        32'd100,       4'b0000, 1'b0, QUIET},
        '{ROW_WRITE, REG_ALT_MAX,        32'hFFFF_FF9C, 4'b0000, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b0011, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        '{ROW_WRITE, REG_ALT_MIN,        32'h0000_8000, 4'b0000, 1'b0, QUIET},
        '{ROW_WRITE, REG_ALT_MAX,        32'h0000_7FFF, 4'b0000, 1'b0, QUIET},
        '{ROW_WRITE, REG_ALT_STEP,       32'h0000_03FF, 4'b0000, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b0010, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        // yaw wrap at the widest circle and largest step
        '{ROW_WRITE, REG_YAW_MIN,        32'h0000_0200, 4'b0000, 1'b0, QUIET},
        '{ROW_WRITE, REG_FULL_CIRCLE,    32'h0000_03FF, 4'b0000, 1'b0, QUIET},
        '{ROW_WRITE, REG_YAW_STEP,       32'h0000_01FF, 4'b0000, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1000, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b0100, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        '{ROW_WRITE, REG_YAW_STEP,       32'd0,         4'b0000, 1'b0, QUIET},
        '{ROW_WRITE, REG_FULL_CIRCLE,    32'd1,         4'b0000, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b0000, 1'b0, QUIET},
        // rest levels rewritten while left and right sit low
        '{ROW_WRITE, REG_REST_LEVELS,    32'd0,         4'b0000, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1100, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b0000, 1'b0, QUIET},
        '{ROW_WRITE, REG_DEBOUNCE_POLLS, 32'd255,       4'b0000, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b1111, 1'b0, QUIET},
        '{ROW_POLL,  REG_DEBOUNCE_POLLS, 32'd0,         4'b0000, 1'b0, QUIET}
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_button_levels = 4'd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [3:0]         m_pushed_events;
    logic [3:0]         m_released_events;
    logic signed [15:0] m_altitude_setpoint;
    logic signed [9:0]  m_yaw_setpoint;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = 5'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    button_debounce_setpoint_adjust_unit dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_button_levels     (s_button_levels),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pushed_events     (m_pushed_events),
        .m_released_events   (m_released_events),
        .m_altitude_setpoint (m_altitude_setpoint),
        .m_yaw_setpoint      (m_yaw_setpoint),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // register mirror
    int         polls_cfg;
    logic [3:0] rest_cfg;
    int         alt_step_cfg;
    int         alt_min_cfg;
    int         alt_max_cfg;
    int         yaw_step_cfg;
    int         yaw_min_cfg;
    int         circle_cfg;

    // lane and setpoint state
    logic [3:0] deb_levels;
    int         disagree [4];
    int         alt_now;
    int         yaw_now;

    result_t    due_reports [$];
    result_t    seen_want;
    idle_mode_t idle_mode = IDLE_NONE;
    int         hold_token = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         mismatches = 0;
    int         polls_sent = 0;
    int         results_seen = 0;
    int         settings_used = 0;
    logic [3:0] held_levels = 4'd0;
    int         run_left = 0;

    function automatic int wrap16(input int v);
        return int'($signed(v[15:0]));
    endfunction

    function automatic int wrap10(input int v);
        return int'($signed(v[9:0]));
    endfunction

    function automatic void reset_model();
        polls_cfg    = int'(RST_DEBOUNCE_POLLS);
        rest_cfg     = RST_REST_LEVELS;
        alt_step_cfg = int'(RST_ALT_STEP);
        alt_min_cfg  = int'(RST_ALT_MIN);
        alt_max_cfg  = int'(RST_ALT_MAX);
        yaw_step_cfg = int'(RST_YAW_STEP);
        yaw_min_cfg  = int'(RST_YAW_MIN);
        circle_cfg   = int'(RST_FULL_CIRCLE);
        deb_levels   = RST_REST_LEVELS;
        for (int i = 0; i < 4; i++) disagree[i] = 0;
        alt_now = 0;
        yaw_now = 0;
    endfunction

    // one poll through the debounce lanes and the setpoint chain
    function automatic result_t debounce_poll(input logic [3:0] lv);
        result_t    r;
        logic [3:0] pushed;
        logic [3:0] released;
        int         c;
        int         a;
        int         y;
        pushed   = '0;
        released = '0;
        for (int i = 0; i < 4; i++) begin
            if (lv[i] != deb_levels[i]) begin
                c = disagree[i] + 1;
                if (c >= polls_cfg) begin
                    deb_levels[i] = lv[i];
                    disagree[i] = 0;
                    if (lv[i] != rest_cfg[i]) pushed[i] = 1'b1;
                    else released[i] = 1'b1;
                end else begin
                    disagree[i] = c & 255;
                end
            end else begin
                disagree[i] = 0;
            end
        end
        if (pushed[BTN_UP]) begin
            a = alt_now + alt_step_cfg;
            if (a > alt_max_cfg) a = alt_max_cfg;
            alt_now = wrap16(a);
        end
        if (pushed[BTN_DOWN]) begin
            a = alt_now - alt_step_cfg;
            if (a < alt_min_cfg) a = alt_min_cfg;
            alt_now = wrap16(a);
        end
        if (pushed[BTN_LEFT]) begin
            y = yaw_now;
            if (y >= yaw_min_cfg + yaw_step_cfg) y = y - yaw_step_cfg;
            else y = y + circle_cfg - yaw_step_cfg;
            yaw_now = wrap10(y);
        end
        if (pushed[BTN_RIGHT]) begin
            y = yaw_now;
            if (y <= yaw_min_cfg + circle_cfg - 1 - yaw_step_cfg) y = y + yaw_step_cfg;
            else y = y - circle_cfg + yaw_step_cfg;
            yaw_now = wrap10(y);
        end
        r.pushed_events     = pushed;
        r.released_events   = released;
        r.altitude_setpoint = alt_now[15:0];
        r.yaw_setpoint      = yaw_now[9:0];
        return r;
    endfunction

    function automatic bit sender_pauses();
        int roll;
        roll = $urandom_range(99);
        return (idle_mode == IDLE_SRC && roll < 70) || (idle_mode == IDLE_BOTH && roll < 36);
    endfunction

    function automatic bit receiver_pauses();
        int roll;
        roll = $urandom_range(99);
        return (idle_mode == IDLE_SNK && roll < 70) || (idle_mode == IDLE_BOTH && roll < 36);
    endfunction

    // mostly held levels long enough to flip, with bounces and noise
    function automatic logic [3:0] next_poll_levels();
        int span;
        int pick;
        if (run_left == 0) begin
            held_levels = held_levels ^ 4'($urandom_range(1, 15));
            span = (polls_cfg < 1) ? 1 : polls_cfg;
            if ($urandom_range(99) < 75) run_left = span + int'($urandom_range(0, 3));
            else run_left = int'($urandom_range(1, span + 1));
        end
        run_left--;
        pick = $urandom_range(99);
        if (pick < 85) return held_levels;
        if (pick < 95) return held_levels ^ (4'b0001 << $urandom_range(0, 3));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic send_poll(input logic [3:0] lv, input logic typed, input result_t want);
        result_t guess;
        @(negedge aclk);
        while (sender_pauses()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_button_levels <= lv;
        do @(posedge aclk); while (!s_ready);
        guess = debounce_poll(lv);
        due_reports.push_back(typed ? want : guess);
        polls_sent++;
    endtask

    // only issued with the result path drained
    task automatic write_register(input reg_index_t sel, input logic [31:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_reports.size() != 0) @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (sel)
            REG_DEBOUNCE_POLLS: polls_cfg    = int'(v[7:0]);
            REG_REST_LEVELS:    rest_cfg     = v[3:0];
            REG_ALT_STEP:       alt_step_cfg = int'(v[9:0]);
            REG_ALT_MIN:        alt_min_cfg  = int'($signed(v[15:0]));
            REG_ALT_MAX:        alt_max_cfg  = int'($signed(v[15:0]));
            REG_YAW_STEP:       yaw_step_cfg = int'(v[8:0]);
            REG_YAW_MIN:        yaw_min_cfg  = int'($signed(v[9:0]));
            REG_FULL_CIRCLE:    circle_cfg   = int'(v[9:0]);
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_phase(input int p);
        int db;
        int rest;
        int astep;
        int amin;
        int amax;
        int ystep;
        int ymin;
        int circ;
        db    = int'($urandom_range(1, 6));
        rest  = int'($urandom_range(0, 15));
        astep = int'($urandom_range(0, 300));
        amin  = int'($urandom_range(0, 65535)) - 32768;
        amax  = amin + int'($urandom_range(0, 4000));
        if (amax > 32767) amax = 32767;
        circ  = int'($urandom_range(1, 1023));
        ystep = int'($urandom_range(0, (circ - 1 > 511) ? 511 : circ - 1));
        ymin  = int'($urandom_range(0, 1023)) - 512;
        case (p)
            1: begin
                db = 1; rest = 0; astep = 0; amin = -32768; amax = -32768;
                ystep = 0; ymin = -512; circ = 1;
            end
            2: begin
                db = 255; rest = 15; astep = 1023; amin = 32767; amax = 32767;
                ystep = 511; ymin = 511; circ = 1023;
            end
            5: db = 0;
            default: ;
        endcase
        write_register(REG_DEBOUNCE_POLLS, db);
        write_register(REG_REST_LEVELS, rest);
        write_register(REG_ALT_STEP, astep);
        write_register(REG_ALT_MIN, amin);
        write_register(REG_ALT_MAX, amax);
        write_register(REG_YAW_STEP, ystep);
        write_register(REG_YAW_MIN, ymin);
        write_register(REG_FULL_CIRCLE, circ);
        settings_used++;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !receiver_pauses();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result beat with nothing pending: pushed %b released %b alt %0d yaw %0d",
                             m_pushed_events, m_released_events,
                             m_altitude_setpoint, m_yaw_setpoint);
            end else begin
                seen_want = due_reports.pop_front();
                if (m_pushed_events !== seen_want.pushed_events ||
                    m_released_events !== seen_want.released_events ||
                    m_altitude_setpoint !== seen_want.altitude_setpoint ||
                    m_yaw_setpoint !== seen_want.yaw_setpoint) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch at beat %0d: want %b %b %0d %0d, got %b %b %0d %0d",
                                 results_seen, seen_want.pushed_events,
                                 seen_want.released_events,
                                 $signed(seen_want.altitude_setpoint),
                                 $signed(seen_want.yaw_setpoint),
                                 m_pushed_events, m_released_events,
                                 m_altitude_setpoint, m_yaw_setpoint);
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results pending", due_reports.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        reset_model();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_mode = IDLE_BOTH;
        for (int k = 0; k < PLAN_ROWS; k++) begin
            if (PLAN[k].kind == ROW_WRITE) write_register(PLAN[k].reg_sel, PLAN[k].wdata);
            else send_poll(PLAN[k].levels, PLAN[k].typed, PLAN[k].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            program_phase(p);
            idle_mode = idle_mode_t'(p % 4);
            // first phase: hold the result side off so the buffer fills
            if (p == 0) hold_token++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_poll(next_poll_levels(), 1'b0, QUIET);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Ran %0d poll beats under %0d register settings plus the directed table,",
                 polls_sent, settings_used);
        $display("with four handshake patterns and one long result hold-off; %0d results checked.",
                 results_seen);
        if (mismatches == 0 && due_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
